[rtl/kms_pkg.sv]
// Shared types, constants and decode functions for the keyboard matrix scanner.
// Used by the interfaces and all kms_* modules; depends on nothing.
package kms_pkg;

  // Field widths
  localparam int unsigned SenseW = 8;
  localparam int unsigned DriveW = 8;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned TickW  = 16;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned LineW  = 3;

  // Register indexes
  localparam logic [IdxW-1:0] RegSettle   = 2'd0;
  localparam logic [IdxW-1:0] RegDebounce = 2'd1;
  localparam logic [IdxW-1:0] RegHold     = 2'd2;

  // Register reset values
  localparam logic [TickW-1:0] SettleRst   = 16'd1;
  localparam logic [TickW-1:0] DebounceRst = 16'd10;
  localparam logic [TickW-1:0] HoldRst     = 16'd240;

  // Shift key position and fixed drive patterns
  localparam logic [SenseW-1:0] ShiftSense = 8'h02;
  localparam logic [DriveW-1:0] ShiftDrive = 8'h80;
  localparam logic [DriveW-1:0] DriveAll   = 8'h00;
  localparam logic [DriveW-1:0] DriveHold  = 8'h7F;
  localparam logic [LineW-1:0]  LastLine   = 3'd7;

  typedef enum logic [1:0] {
    PH_ALL,
    PH_DEB,
    PH_SCAN,
    PH_HOLD
  } phase_e;

  // One classified tick as queued between front and back
  typedef struct packed {
    logic [SenseW-1:0] active;
    logic              any;
  } tick_t;

  // Queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Character tables, one row per sense line, leftmost character is drive line 0
  localparam logic [63:0] PlainRows [8] = '{
    ".\n......",
    "3WA4ZSE.",
    "5RD6CFTX",
    "7YG8BHUV",
    "9IJ0MKON",
    "+PL-.:@,",
    "#*;..=|/",
    "1<.2 .Q."
  };

  localparam logic [63:0] ShiftRows [8] = '{
    ".\n......",
    "#WA$ZSE.",
    "%RD&CFTX",
    "'YG(BHUV",
    ")IJ0MKON",
    "+PL->[@<",
    "#*]..=|?",
    "!<.\" .Q."
  };

  // Index of the lowest set bit, zero for an empty mask
  function automatic logic [LineW-1:0] low_index(input logic [7:0] v);
    logic [LineW-1:0] idx;
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        idx = LineW'(i);
      end
    end
    return idx;
  endfunction

  // Look up a character in the plain or shifted table
  function automatic logic [CodeW-1:0] rom_char(input logic shifted,
                                                input logic [LineW-1:0] row,
                                                input logic [LineW-1:0] col);
    logic [63:0] line;
    logic [7:0]  ch;
    line = shifted ? ShiftRows[row] : PlainRows[row];
    ch   = line[8*(7-int'(col)) +: 8];
    return ch[CodeW-1:0];
  endfunction

endpackage

[rtl/kms_if.sv]
// Handshake channel interfaces for the keyboard matrix scanner: tick input,
// result output and register write. Depends on kms_pkg.
interface kms_in_if;
  logic                       valid;
  logic                       ready;
  logic [kms_pkg::SenseW-1:0] sense_lines;
  modport source (output valid, output sense_lines, input ready);
  modport sink   (input valid, input sense_lines, output ready);
endinterface

interface kms_out_if;
  logic                       valid;
  logic                       ready;
  logic [kms_pkg::DriveW-1:0] drive_lines;
  logic                       key_valid;
  logic [kms_pkg::CodeW-1:0]  key_code;
  modport source (output valid, output drive_lines, output key_valid, output key_code,
                  input ready);
  modport sink   (input valid, input drive_lines, input key_valid, input key_code,
                  output ready);
endinterface

interface kms_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [kms_pkg::IdxW-1:0]  index;
  logic [kms_pkg::TickW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/kms_front.sv]
// Front end: accepts tick words and classifies the sense pins into an active mask.
// Depends on kms_pkg and kms_if.
module kms_front (
  kms_in_if.sink           in_ch,
  input  kms_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output kms_pkg::tick_t   item_o
);

  // Accept while the queue has room
  assign in_ch.ready = ~q_stat_i.full;
  assign push_o      = in_ch.valid & ~q_stat_i.full;

  // Contact pulls a line low: invert and flag any contact
  assign item_o.active = ~in_ch.sense_lines;
  assign item_o.any    = |(~in_ch.sense_lines);

endmodule

[rtl/kms_queue.sv]
// Two-entry queue of classified ticks between front and back.
// Depends on kms_pkg.
module kms_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kms_pkg::tick_t   item_i,
  input  logic             pop_i,
  output kms_pkg::tick_t   head_o,
  output kms_pkg::q_stat_t stat_o
);

  kms_pkg::tick_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & ~stat_o.empty;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/kms_back.sv]
// Back end: scan sequencer, timing registers, decode and output register.
// Depends on kms_pkg and kms_if.
module kms_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  kms_cfg_if.sink          cfg_ch,
  input  logic             q_valid_i,
  input  kms_pkg::tick_t   head_i,
  output logic             pop_o,
  kms_out_if.source        out_ch
);

  localparam int unsigned TickW = kms_pkg::TickW;

  kms_pkg::phase_e phase_q, phase_d;
  logic [TickW-1:0]           settle_q, debounce_q, hold_q;
  logic [TickW-1:0]           wait_q, wait_d, lim;
  logic [kms_pkg::LineW-1:0]  line_q, line_d;
  logic [kms_pkg::SenseW-1:0] sense_q, sense_d, s_eff;
  logic [kms_pkg::DriveW-1:0] drive_q, drive_d, d_eff, pat_d;
  logic                       done, shift_hit, exact, emit;
  logic [kms_pkg::CodeW-1:0]  code_d;
  logic                       out_valid_q;
  logic [kms_pkg::DriveW-1:0] out_drive_q;
  logic                       out_key_q;
  logic [kms_pkg::CodeW-1:0]  out_code_q;

  // Register writes, indexes beyond the list are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= kms_pkg::SettleRst;
      debounce_q <= kms_pkg::DebounceRst;
      hold_q     <= kms_pkg::HoldRst;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        kms_pkg::RegSettle:   settle_q   <= cfg_ch.data;
        kms_pkg::RegDebounce: debounce_q <= cfg_ch.data;
        kms_pkg::RegHold:     hold_q     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Step one tick when a word is queued and the output register is free
  assign pop_o = q_valid_i & (~out_valid_q | out_ch.ready);

  // Wait limit of the current phase; a zero limit ends on the first tick
  always_comb begin
    case (phase_q)
      kms_pkg::PH_DEB:  lim = debounce_q;
      kms_pkg::PH_HOLD: lim = hold_q;
      default:          lim = settle_q;
    endcase
    done = ({1'b0, wait_q} + 17'd1) >= {1'b0, lim};
  end

  // Shift handling and table lookup from the held masks
  always_comb begin
    shift_hit = sense_q[1] & drive_q[7];
    exact     = (sense_q == kms_pkg::ShiftSense) & (drive_q == kms_pkg::ShiftDrive);
    emit      = ~(shift_hit & exact);
    s_eff     = (shift_hit && sense_q != kms_pkg::ShiftSense) ?
                (sense_q & ~kms_pkg::ShiftSense) : sense_q;
    d_eff     = (shift_hit && drive_q != kms_pkg::ShiftDrive) ?
                (drive_q & ~kms_pkg::ShiftDrive) : drive_q;
    code_d    = kms_pkg::rom_char(shift_hit, kms_pkg::low_index(s_eff),
                                  kms_pkg::low_index(d_eff));
  end

  // Next state of the scan sequencer
  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q + 16'd1;
    line_d  = line_q;
    sense_d = sense_q;
    drive_d = drive_q;
    case (phase_q)
      kms_pkg::PH_ALL: begin
        if (done) begin
          wait_d = '0;
          if (head_i.any) begin
            sense_d = head_i.active;
            phase_d = kms_pkg::PH_DEB;
          end
        end
      end
      kms_pkg::PH_DEB: begin
        if (done) begin
          wait_d = '0;
          if (head_i.active == sense_q) begin
            line_d  = '0;
            drive_d = '0;
            phase_d = kms_pkg::PH_SCAN;
          end else begin
            phase_d = kms_pkg::PH_ALL;
          end
        end
      end
      kms_pkg::PH_SCAN: begin
        if (done) begin
          wait_d = '0;
          if (head_i.any) begin
            drive_d = drive_q | (kms_pkg::DriveW'(1) << line_q);
          end
          if (line_q == kms_pkg::LastLine) begin
            phase_d = kms_pkg::PH_HOLD;
          end else begin
            line_d = line_q + 3'd1;
          end
        end
      end
      kms_pkg::PH_HOLD: begin
        if (done) begin
          wait_d  = '0;
          phase_d = kms_pkg::PH_ALL;
        end
      end
      default: begin
        wait_d  = '0;
        phase_d = kms_pkg::PH_ALL;
      end
    endcase

    // Drive pattern applied after this tick
    case (phase_d)
      kms_pkg::PH_SCAN: pat_d = ~(kms_pkg::DriveW'(1) << line_d);
      kms_pkg::PH_HOLD: pat_d = kms_pkg::DriveHold;
      default:          pat_d = kms_pkg::DriveAll;
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kms_pkg::PH_ALL;
      wait_q  <= '0;
      line_q  <= '0;
      sense_q <= '0;
      drive_q <= '0;
    end else if (pop_o) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      line_q  <= line_d;
      sense_q <= sense_d;
      drive_q <= drive_d;
    end
  end

  // Output register: load on a step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_drive_q <= pat_d;
      out_key_q   <= (phase_q == kms_pkg::PH_HOLD) & done & emit;
      out_code_q  <= ((phase_q == kms_pkg::PH_HOLD) & done & emit) ? code_d : '0;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.drive_lines = out_drive_q;
  assign out_ch.key_valid   = out_key_q;
  assign out_ch.key_code    = out_code_q;

endmodule

[rtl/keyboard_matrix_scanner_core.sv]
// Top level of the keyboard matrix scanner: front, queue and back end.
// Depends on kms_pkg, kms_if, kms_front, kms_queue and kms_back.
//
// Usage:
//   in_ch  carries one word per timer tick: the eight raw sense pins.
//   out_ch returns one word per tick: the drive pattern to apply next,
//          key_valid and key_code (zero unless a character is emitted).
//   cfg_ch writes the timing registers: index 0 settle, 1 debounce,
//          2 hold, in ticks; other indexes are ignored. Write only while
//          no tick is in flight.
// Throughput: one tick per cycle while out_ch is ready; the sequencer takes one step
//   per cycle from the two-entry queue and holds while the output register waits.
// Path: an accepted tick is written into a queue entry, then the sequencer steps
//   it into the output register, which holds its result.
// Reset: the queue and output register empty, timing registers return to
//   1, 10 and 240, the sequencer starts in the all-low settle phase.
// Stall: while out_ch is not ready the result holds; the queue absorbs up
//   to two more ticks before in_ch drops ready.
module keyboard_matrix_scanner_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  kms_in_if.sink    in_ch,
  kms_out_if.source out_ch,
  kms_cfg_if.sink   cfg_ch
);

  kms_pkg::tick_t   push_item, head;
  kms_pkg::q_stat_t q_stat;
  logic             push, pop;

  kms_front u_front (
    .in_ch    (in_ch),
    .q_stat_i (q_stat),
    .push_o   (push),
    .item_o   (push_item)
  );

  kms_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  kms_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_ch    (cfg_ch),
    .q_valid_i (~q_stat.empty),
    .head_i    (head),
    .pop_o     (pop),
    .out_ch    (out_ch)
  );

  // An accepted tick is queued on the next cycle
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !q_stat.empty)
    else $error("accepted tick missing from queue");

  // No result word without a queued tick to produce it
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("sequencer stepped on an empty queue");

  // A character comes only as the scan restarts with all lines low
  a_key_all_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.key_valid) |-> (out_ch.drive_lines == kms_pkg::DriveAll))
    else $error("character emitted outside the all-low phase");

  // Without a character the code reads zero
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.key_valid) |-> (out_ch.key_code == '0))
    else $error("key code set without key_valid");

endmodule

[sim/testbench.sv]
// Self-checking testbench for keyboard_matrix_scanner_core: a table of directed ticks,
// key presses and register writes, then randomized key sessions under several timings.
// Depends on kms_pkg, the kms_*_if interfaces and the scanner RTL.
module testbench;

  localparam logic [kms_pkg::IdxW-1:0] RegSpare = 2'd3;  // unmapped index, writes are dropped
  localparam int PhaseTicks = 135;
  localparam int PressCap = 2000;
  localparam int QuietLimit = 1000;

  // One result word of the scanner
  typedef struct packed {
    logic [kms_pkg::DriveW-1:0] drive;
    logic                       key_valid;
    logic [kms_pkg::CodeW-1:0]  code;
  } scan_word_t;

  typedef enum logic [1:0] {
    REL_NONE,
    REL_DEB,
    REL_SCAN
  } release_e;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_KEYS,
    ROW_REG
  } row_kind_e;

  // One line of the directed table
  typedef struct packed {
    row_kind_e                  kind;
    logic [kms_pkg::SenseW-1:0] sense;
    logic [63:0]                keys;
    release_e                   rel;
    logic                       stop_hold;
    logic [kms_pkg::IdxW-1:0]   index;
    logic [kms_pkg::TickW-1:0]  data;
    logic                       typed;
    scan_word_t                 want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  kms_in_if  in_ch ();
  kms_out_if out_ch ();
  kms_cfg_if cfg_ch ();

  keyboard_matrix_scanner_core DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Scanner state as the testbench sees it
  logic [kms_pkg::TickW-1:0]  cfg_settle;
  logic [kms_pkg::TickW-1:0]  cfg_debounce;
  logic [kms_pkg::TickW-1:0]  cfg_hold;
  kms_pkg::phase_e            scan_phase;
  logic [kms_pkg::TickW-1:0]  tick_count;
  logic [kms_pkg::LineW-1:0]  line_sel;
  logic [kms_pkg::SenseW-1:0] sense_hits;
  logic [kms_pkg::DriveW-1:0] drive_hits;

  scan_word_t scanner_words[$];
  scan_word_t last_word;
  stim_row_t  plan[$];
  int         sent_ticks;
  int         bad_words;
  int         quiet_cycles;
  int         send_gap;
  int         recv_gap;

  // Character rows, leftmost character is drive line 0
  function automatic logic [63:0] char_row(input logic shifted,
                                           input logic [kms_pkg::LineW-1:0] s);
    case ({shifted, s})
      4'h0, 4'h8: return ".\n......";
      4'h1: return "3WA4ZSE.";
      4'h2: return "5RD6CFTX";
      4'h3: return "7YG8BHUV";
      4'h4: return "9IJ0MKON";
      4'h5: return "+PL-.:@,";
      4'h6: return "#*;..=|/";
      4'h7: return "1<.2 .Q.";
      4'h9: return "#WA$ZSE.";
      4'hA: return "%RD&CFTX";
      4'hB: return "'YG(BHUV";
      4'hC: return ")IJ0MKON";
      4'hD: return "+PL->[@<";
      4'hE: return "#*]..=|?";
      default: return "!<.\" .Q.";
    endcase
  endfunction

  function automatic logic [kms_pkg::CodeW-1:0] key_char(input logic shifted,
                                                         input logic [kms_pkg::LineW-1:0] s,
                                                         input logic [kms_pkg::LineW-1:0] d);
    logic [63:0] row;
    row = char_row(shifted, s);
    row = row >> (8 * (7 - int'(d)));
    return row[kms_pkg::CodeW-1:0];
  endfunction

  function automatic logic [kms_pkg::LineW-1:0] lowest_line(input logic [7:0] m);
    for (int i = 0; i < 8; i++) begin
      if (m[i]) return kms_pkg::LineW'(i);
    end
    return '0;
  endfunction

  // True on the tick that ends a wait of n ticks; zero counts as one
  function automatic logic tick_ends(input logic [kms_pkg::TickW-1:0] n);
    if ({1'b0, tick_count} + 17'd1 >= {1'b0, n}) return 1'b1;
    tick_count = tick_count + 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [kms_pkg::DriveW-1:0] drive_now();
    case (scan_phase)
      kms_pkg::PH_SCAN: return ~(8'h01 << line_sel);
      kms_pkg::PH_HOLD: return kms_pkg::DriveHold;
      default:          return kms_pkg::DriveAll;
    endcase
  endfunction

  // Advance the scanner by one tick and return the word it emits
  function automatic scan_word_t advance_scanner(input logic [kms_pkg::SenseW-1:0] pins);
    logic [kms_pkg::SenseW-1:0] act;
    logic [kms_pkg::SenseW-1:0] s;
    logic [kms_pkg::DriveW-1:0] d;
    scan_word_t                 w;
    act = ~pins;
    w = '0;
    case (scan_phase)
      kms_pkg::PH_DEB: begin
        if (tick_ends(cfg_debounce)) begin
          if (act == sense_hits) begin
            line_sel = '0;
            drive_hits = '0;
            scan_phase = kms_pkg::PH_SCAN;
          end else begin
            scan_phase = kms_pkg::PH_ALL;
          end
          tick_count = '0;
        end
      end
      kms_pkg::PH_SCAN: begin
        if (tick_ends(cfg_settle)) begin
          if (act != '0) drive_hits[line_sel] = 1'b1;
          if (line_sel == kms_pkg::LastLine) scan_phase = kms_pkg::PH_HOLD;
          else line_sel = line_sel + 1'b1;
          tick_count = '0;
        end
      end
      kms_pkg::PH_HOLD: begin
        if (tick_ends(cfg_hold)) begin
          s = sense_hits;
          d = drive_hits;
          if ((s & kms_pkg::ShiftSense) != '0 && (d & kms_pkg::ShiftDrive) != '0) begin
            // shift pressed: strip it, and drop the key when shift stands alone
            if (s == kms_pkg::ShiftSense && d == kms_pkg::ShiftDrive) begin
              s = '0;
              d = '0;
            end else begin
              if (s != kms_pkg::ShiftSense) s = s & ~kms_pkg::ShiftSense;
              if (d != kms_pkg::ShiftDrive) d = d & ~kms_pkg::ShiftDrive;
            end
            if (s != '0 && d != '0) begin
              w.key_valid = 1'b1;
              w.code = key_char(1'b1, lowest_line(s), lowest_line(d));
            end
          end else begin
            w.key_valid = 1'b1;
            w.code = key_char(1'b0, lowest_line(s), lowest_line(d));
          end
          scan_phase = kms_pkg::PH_ALL;
          tick_count = '0;
        end
      end
      default: begin
        if (tick_ends(cfg_settle)) begin
          if (act != '0) begin
            sense_hits = act;
            scan_phase = kms_pkg::PH_DEB;
          end
          tick_count = '0;
        end
      end
    endcase
    w.drive = drive_now();
    return w;
  endfunction

  // Sense lines seen through a set of closed switches, bit 8*sense+drive
  function automatic logic [kms_pkg::SenseW-1:0] contacts(input logic [63:0] keys,
                                                          input logic [kms_pkg::DriveW-1:0] drive);
    logic [kms_pkg::SenseW-1:0] hit;
    for (int s = 0; s < 8; s++) hit[s] = |(keys[8*s +: 8] & ~drive);
    return hit;
  endfunction

  function automatic logic [63:0] key_bit(input int s, input int d);
    return 64'd1 << (8 * s + d);
  endfunction

  function automatic scan_word_t word_of(input logic [kms_pkg::DriveW-1:0] d, input logic v,
                                         input logic [kms_pkg::CodeW-1:0] c);
    scan_word_t w;
    w.drive = d;
    w.key_valid = v;
    w.code = c;
    return w;
  endfunction

  function automatic stim_row_t tick_row(input logic [kms_pkg::SenseW-1:0] pins,
                                         input logic typed, input scan_word_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.sense = pins;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t key_row(input logic [63:0] keys, input release_e rel,
                                        input logic stop_hold, input logic typed,
                                        input scan_word_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_KEYS;
    r.keys = keys;
    r.rel = rel;
    r.stop_hold = stop_hold;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [kms_pkg::IdxW-1:0] idx,
                                        input logic [kms_pkg::TickW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.index = idx;
    r.data = val;
    return r;
  endfunction

  // Offer one tick word, hold it until accepted, then predict its result
  task automatic push_tick(input logic [kms_pkg::SenseW-1:0] pins);
    while ($urandom_range(99) < send_gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sense_lines <= pins;
    do @(posedge clk); while (!in_ch.ready);
    last_word = advance_scanner(pins);
    scanner_words.push_back(last_word);
    sent_ticks++;
    @(negedge clk);
  endtask

  // Hold a set of keys, answering the drive pattern, until the scan is over
  task automatic run_press(input logic [63:0] keys, input release_e rel, input logic stop_hold,
                           input int noise_pct, input logic typed, input scan_word_t want);
    logic [63:0]                live;
    logic [kms_pkg::SenseW-1:0] pins;
    kms_pkg::phase_e            was;
    int                         n;
    logic                       done;
    done = 1'b0;
    n = 0;
    while (!done && n < PressCap) begin
      live = keys;
      if ((rel == REL_DEB && scan_phase == kms_pkg::PH_DEB) ||
          (rel == REL_SCAN && scan_phase == kms_pkg::PH_SCAN))
        live = '0;
      pins = ~contacts(live, drive_now());
      if ($urandom_range(99) < noise_pct) pins = kms_pkg::SenseW'($urandom);
      was = scan_phase;
      push_tick(pins);
      if (typed && last_word.key_valid) scanner_words[scanner_words.size() - 1] = want;
      n++;
      done = last_word.key_valid ||
             (was != kms_pkg::PH_ALL && scan_phase == kms_pkg::PH_ALL) ||
             (stop_hold && scan_phase == kms_pkg::PH_HOLD);
    end
  endtask

  // Drop valid and wait until every word in flight has come back
  task automatic drain_words();
    in_ch.valid <= 1'b0;
    while (scanner_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [kms_pkg::IdxW-1:0] idx,
                           input logic [kms_pkg::TickW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      kms_pkg::RegSettle:   cfg_settle = val;
      kms_pkg::RegDebounce: cfg_debounce = val;
      kms_pkg::RegHold:     cfg_hold = val;
      default:              ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: stall at random on the falling edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_gap);
    end
  end

  // Compare every accepted word with the oldest prediction
  always @(posedge clk) begin
    scan_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (scanner_words.size() == 0) begin
        bad_words++;
        $display("%0t: unexpected word drive %02h valid %0b code %02h", $time,
                 out_ch.drive_lines, out_ch.key_valid, out_ch.key_code);
      end else begin
        want = scanner_words.pop_front();
        if (want.drive !== out_ch.drive_lines || want.key_valid !== out_ch.key_valid ||
            want.code !== out_ch.key_code) begin
          bad_words++;
          $display("%0t: expected drive %02h valid %0b code %02h, %s", $time,
                   want.drive, want.key_valid, want.code, "got");
          $display("%0t: got drive %02h valid %0b code %02h", $time,
                   out_ch.drive_lines, out_ch.key_valid, out_ch.key_code);
        end
      end
    end
  end

  // End the run when no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [63:0] keys;
    release_e    rel;
    int          pick;
    int          first_tick;
    int          fillers;
    int          burst;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sense_lines = 8'hFF;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = kms_pkg::RegSettle;
    cfg_ch.data = '0;
    quiet_cycles = 0;
    bad_words = 0;
    sent_ticks = 0;
    send_gap = 18;
    recv_gap = 48;
    cfg_settle = kms_pkg::SettleRst;
    cfg_debounce = kms_pkg::DebounceRst;
    cfg_hold = kms_pkg::HoldRst;
    scan_phase = kms_pkg::PH_ALL;
    tick_count = '0;
    line_sel = '0;
    sense_hits = '0;
    drive_hits = '0;
    last_word = '0;

    // Directed table
    plan.push_back(tick_row(8'hFF, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(key_row(key_bit(1, 2), REL_NONE, 1'b0, 1'b1,
                           word_of(kms_pkg::DriveAll, 1'b1, kms_pkg::CodeW'("A"))));
    plan.push_back(reg_row(kms_pkg::RegSettle, '0));
    plan.push_back(reg_row(kms_pkg::RegDebounce, '0));
    plan.push_back(reg_row(kms_pkg::RegHold, '0));
    plan.push_back(reg_row(RegSpare, 16'hFFFF));
    plan.push_back(tick_row(8'h00, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(tick_row(8'hFF, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(tick_row(8'h55, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(tick_row(8'hAA, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(key_row(key_bit(1, 7), REL_NONE, 1'b0, 1'b0, '0));
    plan.push_back(key_row(key_bit(1, 0) | key_bit(1, 7), REL_NONE, 1'b0, 1'b1,
                           word_of(kms_pkg::DriveAll, 1'b1, kms_pkg::CodeW'("#"))));
    plan.push_back(key_row(key_bit(1, 3) | key_bit(1, 7), REL_NONE, 1'b0, 1'b1,
                           word_of(kms_pkg::DriveAll, 1'b1, kms_pkg::CodeW'("$"))));
    plan.push_back(key_row(key_bit(2, 0) | key_bit(1, 7), REL_NONE, 1'b0, 1'b0, '0));
    plan.push_back(key_row('1, REL_NONE, 1'b0, 1'b0, '0));
    plan.push_back(key_row(key_bit(7, 7), REL_NONE, 1'b0, 1'b1,
                           word_of(kms_pkg::DriveAll, 1'b1, kms_pkg::CodeW'("."))));
    plan.push_back(key_row(key_bit(0, 1), REL_NONE, 1'b0, 1'b1,
                           word_of(kms_pkg::DriveAll, 1'b1, kms_pkg::CodeW'("\n"))));
    plan.push_back(key_row(key_bit(4, 4), REL_DEB, 1'b0, 1'b0, '0));
    plan.push_back(key_row(key_bit(4, 4), REL_SCAN, 1'b0, 1'b1,
                           word_of(kms_pkg::DriveAll, 1'b1, kms_pkg::CodeW'("9"))));
    // Long waits cut short by lowering the register mid-wait
    plan.push_back(reg_row(kms_pkg::RegSettle, 16'hFFFF));
    plan.push_back(tick_row(8'h00, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(tick_row(8'h00, 1'b1, word_of(kms_pkg::DriveAll, 1'b0, '0)));
    plan.push_back(reg_row(kms_pkg::RegSettle, 16'd1));
    plan.push_back(tick_row(8'h00, 1'b0, '0));
    plan.push_back(reg_row(kms_pkg::RegDebounce, 16'hFFFF));
    plan.push_back(reg_row(kms_pkg::RegHold, 16'hFFFF));
    plan.push_back(tick_row(8'h00, 1'b0, '0));
    plan.push_back(reg_row(kms_pkg::RegDebounce, 16'd1));
    plan.push_back(key_row('1, REL_NONE, 1'b1, 1'b0, '0));
    plan.push_back(tick_row(8'hFF, 1'b1, word_of(kms_pkg::DriveHold, 1'b0, '0)));
    plan.push_back(reg_row(kms_pkg::RegHold, 16'd1));
    plan.push_back(tick_row(8'hFF, 1'b0, '0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_TICK: begin
          push_tick(plan[i].sense);
          if (plan[i].typed) scanner_words[scanner_words.size() - 1] = plan[i].want;
        end
        ROW_KEYS: begin
          run_press(plan[i].keys, plan[i].rel, plan[i].stop_hold, 0, plan[i].typed,
                    plan[i].want);
        end
        default: begin
          drain_words();
          write_reg(plan[i].index, plan[i].data);
        end
      endcase
    end

    // Random key sessions, a fresh timing set per phase
    for (int p = 0; p < 6; p++) begin
      drain_words();
      send_gap = (p < 2) ? 18 : (p < 4) ? 48 : 0;
      recv_gap = (p < 2) ? 48 : (p < 4) ? 18 : 0;
      write_reg(kms_pkg::RegSettle, kms_pkg::TickW'($urandom_range(3)));
      write_reg(kms_pkg::RegDebounce, kms_pkg::TickW'($urandom_range(5)));
      write_reg(kms_pkg::RegHold, kms_pkg::TickW'($urandom_range(12)));
      write_reg(RegSpare, kms_pkg::TickW'($urandom));
      first_tick = sent_ticks;
      fillers = 0;
      while (sent_ticks - first_tick - fillers < PhaseTicks) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          // raw noise on the sense pins
          burst = $urandom_range(1, 8);
          repeat (burst) push_tick(kms_pkg::SenseW'($urandom));
        end else if (pick < 18) begin
          burst = $urandom_range(1, 4);
          repeat (burst) push_tick(8'hFF);
          fillers += burst;
        end else begin
          keys = key_bit($urandom_range(7), $urandom_range(7));
          pick = $urandom_range(99);
          if (pick < 25) keys = keys | key_bit(1, 7);
          else if (pick < 32) keys = key_bit(1, 7);
          else if (pick < 45)
            keys = keys | key_bit($urandom_range(7), $urandom_range(7)) |
                   key_bit($urandom_range(7), $urandom_range(7));
          else if (pick < 50) keys = {$urandom, $urandom};
          if (keys == '0) keys = key_bit(0, 0);
          pick = $urandom_range(99);
          rel = (pick < 8) ? REL_DEB : (pick < 16) ? REL_SCAN : REL_NONE;
          run_press(keys, rel, 1'b0, 2, 1'b0, '0);
        end
      end
    end

    drain_words();
    repeat (8) @(negedge clk);
    if (bad_words == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/kms_pkg.sv
rtl/kms_if.sv
rtl/kms_front.sv
rtl/kms_queue.sv
rtl/kms_back.sv
rtl/keyboard_matrix_scanner_core.sv
sim/testbench.sv
